>>> design/clla_pkg.sv
// ----------------------------------------------------------------------------
// clla_pkg
// Shared field widths, status codes and state type for the circular log
// space allocator.
// ----------------------------------------------------------------------------
package clla_pkg;

    // request fields
    localparam int KEY_W       = 8;
    localparam int VAL_W       = 16;
    localparam int IN_DATA_W   = 24;

    // result fields
    localparam int IDX_W       = 6;
    localparam int OFS_W       = 20;
    localparam int SIZE_W      = 17;
    localparam int ROUND_W     = 32;
    localparam int LIVE_W      = 27;
    localparam int OUT_DATA_W  = 104;
    localparam int OUT_USER_W  = 1;

    // block count register
    localparam int CNT_W       = 7;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    // result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TOO_BIG = 1'b1;

    // controller state: RAM clearing sweep, then normal operation
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } alloc_state_t;

endpackage

>>> design/circular_log_space_allocator.sv
// ----------------------------------------------------------------------------
// circular_log_space_allocator
// Allocates space for key/value items in a ring of fixed-size log blocks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request beat per item (key and value lengths).
//   m_axis: one result beat per request: tuser is the status (too-big flag),
//           tdata holds block index, offset, item size, round and live bytes.
//   cfg:    writes block_count (number of blocks in the ring); always ready.
//           Write it only while the block is idle.
// Output: each result is registered in the output buffer before it is presented.
// Throughput: one request per cycle while s_axis_tready is high. A request that
//   moves allocation to a new block drops s_axis_tready while the free count of
//   the block after it is prefetched from the registered free-space RAM read. A
//   config write drops s_axis_tready for the same reason.
// Reset: all MAX_BLOCKS entries of the free-space RAM are swept to BLOCK_BYTES,
//   one entry per cycle; s_axis_tready stays low during the sweep and in the
//   cycle after it while the first prefetch loads.
// Stall: a two-beat output buffer keeps accepting one more request while
//   m_axis is stalled; s_axis_tready then drops until the buffer drains.
// ----------------------------------------------------------------------------
module circular_log_space_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int BLOCK_BYTES  = 1048576,
    parameter int BATCH_BYTES  = 32768,
    parameter int HEADER_BYTES = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config: block_count
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clla_pkg::CNT_W-1:0]        cfg_data,
    // requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] key_len, [23:8] val_len
    input  logic [clla_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] block_index, [25:6] offset, [42:26] item_bytes,
    // [74:43] round_count, [101:75] live_bytes, [103:102] zero
    output logic [clla_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] status
    output logic [clla_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

    import clla_pkg::*;

    localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NUM_W  = ADDR_W + 1;
    localparam int FW     = $clog2(BLOCK_BYTES + 1);
    localparam int CW     = (FW > SIZE_W) ? FW : SIZE_W;
    localparam int BUF_W  = OUT_DATA_W + OUT_USER_W;
    localparam logic [FW-1:0]     FULL_FREE = FW'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BLOCKS - 1);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    alloc_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [CNT_W-1:0]     block_count_reg;
    logic [ADDR_W-1:0]    cur_reg, cur_next;
    logic [FW-1:0]        cur_free_reg, cur_free_next;
    logic [FW-1:0]        wofs_reg, wofs_next;
    logic [ROUND_W-1:0]   rounds_reg, rounds_next;
    logic [LIVE_W-1:0]    live_reg, live_next;
    logic                 pf_ok_reg, pf_ok_next;

    // ------------------------------------------------------------------
    // combinational signals
    // ------------------------------------------------------------------
    logic                 run_mode;
    logic                 clearing;
    logic                 cfg_fire;
    logic                 in_fire;
    logic                 alloc_fire;
    logic                 move_fire;
    logic [KEY_W-1:0]     klen;
    logic [VAL_W-1:0]     vlen;
    logic [SIZE_W-1:0]    size;
    logic                 too_big;
    logic                 need_move;
    logic [NUM_W-1:0]     n_eff;
    logic [NUM_W-1:0]     cur_inc;
    logic                 step_fwd;
    logic [ADDR_W-1:0]    nxt_addr;
    logic [FW-1:0]        mem_rdata;
    logic [FW-1:0]        nxt_free;
    logic                 do_reclaim;
    logic [ADDR_W-1:0]    base_cur;
    logic [FW-1:0]        base_free;
    logic [FW-1:0]        base_ofs;
    logic [ROUND_W-1:0]   base_rounds;
    logic [LIVE_W-1:0]    base_live;
    logic [FW-1:0]        free_after;
    logic [FW-1:0]        ofs_after;
    logic [LIVE_W-1:0]    live_after;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [FW-1:0]        ram_wdata;
    logic [31:0]          idx_wide;
    logic [31:0]          ofs_wide;
    logic [FW-1:0]        res_ofs;
    logic                 res_status;
    logic [ROUND_W-1:0]   res_rounds;
    logic [LIVE_W-1:0]    res_live;
    logic                 buf_in_ready;
    logic [BUF_W-1:0]     buf_in_data;
    logic [BUF_W-1:0]     buf_out_data;

    // ------------------------------------------------------------------
    // controller: clearing sweep then run
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                run_mode = 1'b0;
            end
            ST_RUN:
            begin
                clearing = 1'b0;
                run_mode = 1'b1;
            end
            default:
            begin
                clearing = 1'b0;
                run_mode = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s_axis_tready = run_mode && pf_ok_reg && buf_in_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign alloc_fire    = in_fire && !too_big;
    assign move_fire     = alloc_fire && need_move;

    // ------------------------------------------------------------------
    // item size: header plus both lengths rounded up to 8
    // ------------------------------------------------------------------
    assign klen = s_axis_tdata[KEY_W-1:0];
    assign vlen = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    assign size = SIZE_W'(HEADER_BYTES)
                + ((SIZE_W'(klen) + SIZE_W'(7)) & ~SIZE_W'(7))
                + ((SIZE_W'(vlen) + SIZE_W'(7)) & ~SIZE_W'(7));
    assign too_big   = 32'(size) > 32'(BATCH_BYTES);
    assign need_move = CW'(cur_free_reg) < CW'(size);

    // ------------------------------------------------------------------
    // next block in the ring and its prefetched free count
    // ------------------------------------------------------------------
    always_comb
    begin
        if (block_count_reg == '0)
        begin
            n_eff = NUM_W'(1);
        end
        else if (32'(block_count_reg) > 32'(MAX_BLOCKS))
        begin
            n_eff = NUM_W'(MAX_BLOCKS);
        end
        else
        begin
            n_eff = NUM_W'(block_count_reg);
        end
    end

    assign cur_inc    = {1'b0, cur_reg} + NUM_W'(1);
    assign step_fwd   = cur_inc < n_eff;
    assign nxt_addr   = step_fwd ? cur_inc[ADDR_W-1:0] : '0;
    assign nxt_free   = (nxt_addr == cur_reg) ? cur_free_reg : mem_rdata;
    assign do_reclaim = !step_fwd || (rounds_reg != '0);

    // ------------------------------------------------------------------
    // block selection and reclaim
    // ------------------------------------------------------------------
    always_comb
    begin
        if (need_move)
        begin
            base_cur    = nxt_addr;
            base_ofs    = '0;
            base_rounds = step_fwd ? rounds_reg : rounds_reg + ROUND_W'(1);
            if (do_reclaim)
            begin
                base_free = FULL_FREE;
                base_live = live_reg - LIVE_W'(FULL_FREE - nxt_free);
            end
            else
            begin
                base_free = nxt_free;
                base_live = live_reg;
            end
        end
        else
        begin
            base_cur    = cur_reg;
            base_ofs    = wofs_reg;
            base_rounds = rounds_reg;
            base_free   = cur_free_reg;
            base_live   = live_reg;
        end
    end

    // ------------------------------------------------------------------
    // allocation inside the chosen block
    // ------------------------------------------------------------------
    assign free_after = (CW'(base_free) >= CW'(size))
                      ? FW'(CW'(base_free) - CW'(size)) : '0;
    assign ofs_after  = FW'(CW'(base_ofs) + CW'(size));
    assign live_after = base_live + LIVE_W'(size);

    // ------------------------------------------------------------------
    // state update
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_next      = cur_reg;
        cur_free_next = cur_free_reg;
        wofs_next     = wofs_reg;
        rounds_next   = rounds_reg;
        live_next     = live_reg;
        if (alloc_fire)
        begin
            cur_next      = base_cur;
            cur_free_next = free_after;
            wofs_next     = ofs_after;
            rounds_next   = base_rounds;
            live_next     = live_after;
        end
    end

    // prefetch stays good while the ring position and size hold still
    assign pf_ok_next = run_mode && !move_fire && !cfg_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            block_count_reg <= CNT_RESET;
            cur_reg         <= '0;
            cur_free_reg    <= FULL_FREE;
            wofs_reg        <= '0;
            rounds_reg      <= '0;
            live_reg        <= '0;
            pf_ok_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            cur_free_reg <= cur_free_next;
            wofs_reg     <= wofs_next;
            rounds_reg   <= rounds_next;
            live_reg     <= live_next;
            pf_ok_reg    <= pf_ok_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_fire)
            begin
                block_count_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // free-space RAM: sweep on reset, write back the block being left
    // ------------------------------------------------------------------
    assign ram_we    = clearing || move_fire;
    assign ram_waddr = clearing ? clr_addr_reg : cur_reg;
    assign ram_wdata = clearing ? FULL_FREE : cur_free_reg;

    clla_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_BLOCKS)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (nxt_addr),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // result beat
    // ------------------------------------------------------------------
    assign res_status = too_big ? STATUS_TOO_BIG : STATUS_OK;
    assign idx_wide   = 32'(too_big ? cur_reg : base_cur);
    assign res_ofs    = too_big ? '0 : base_ofs;
    assign ofs_wide   = 32'(res_ofs);
    assign res_rounds = too_big ? rounds_reg : base_rounds;
    assign res_live   = too_big ? live_reg : live_after;

    assign buf_in_data = {res_status, 2'b00, res_live, res_rounds, size,
                          ofs_wide[OFS_W-1:0], idx_wide[IDX_W-1:0]};

    clla_skid #(
        .WIDTH (BUF_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_fire),
        .in_ready  (buf_in_ready),
        .in_data   (buf_in_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (buf_out_data)
    );

    assign m_axis_tdata = buf_out_data[OUT_DATA_W-1:0];
    assign m_axis_tuser = buf_out_data[BUF_W-1:OUT_DATA_W];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a move reloads the prefetch, so the following cycle takes no request
    a_move_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        move_fire |=> !s_axis_tready)
        else $error("request taken while prefetch was stale");

    // the current block never holds more free bytes than a block has
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_free_reg <= FULL_FREE)
        else $error("current block free count above block size");

    // a round is counted only by a move that lands on block zero
    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (rounds_reg != $past(rounds_reg)) |-> $past(move_fire) && (cur_reg == '0))
        else $error("round count changed without a wrap to block zero");

    // the live total changes only through an accepted allocation
    a_live_source: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg != $past(live_reg)) |-> $past(alloc_fire))
        else $error("live byte total changed without an allocation");

endmodule

>>> design/clla_ram.sv
// ----------------------------------------------------------------------------
// clla_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module clla_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/clla_skid.sv
// ----------------------------------------------------------------------------
// clla_skid
// Two-entry output buffer: an output register plus a skid register, so the
// upstream ready is registered and never waits on the downstream ready.
// ----------------------------------------------------------------------------
module clla_skid #(
    parameter int WIDTH = 105
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    // a beat parked in the skid stage never overtakes the one in the output
    a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg) && !$past(out_ready))
        else $error("skid entry filled while output was free");

    // with a beat waiting in the skid stage the output register is occupied
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(out_data_reg))
        else $error("output payload changed while stalled");

endmodule
